// File: rtl/adr_pkg.sv
// adr_pkg: widths, opcodes, constants and divider handshake types for the
// accelerometer dead reckoning integrator. no dependencies.
package adr_pkg;

    localparam int ACC_W  = 16;   // raw sample
    localparam int ACOR_W = 17;   // offset-corrected sample
    localparam int ASUM_W = 18;   // sum of new and previous corrected samples
    localparam int VEL_W  = 48;
    localparam int POS_W  = 64;
    localparam int TIME_W = 32;
    localparam int DT_W   = 16;   // elapsed time saturates at all ones

    localparam int MAG_W  = VEL_W + 1;   // magnitude of a velocity sum
    localparam int MUL_A_W = 32;
    localparam int MUL_W  = MUL_A_W + DT_W;
    localparam int PROD_W = 64;

    // divide by 2000 = shift by 4, then divide by 125 a byte per cycle
    localparam int DIV_SHIFT = 4;
    localparam int DIV_K     = 125;
    localparam int DIV_REM_W = 7;
    localparam int DIV_DIGIT = 8;
    localparam int DIV_STEPS = PROD_W / DIV_DIGIT;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int DIV_QW    = 56;   // signed quotient, magnitude below 2^54

    // calibration run length, a power of two
    localparam int CAL_SAMPLES = 128;
    localparam int CAL_SHIFT   = $clog2(CAL_SAMPLES);
    localparam int CAL_SUM_W   = ACC_W + CAL_SHIFT;
    localparam int CAL_CNT_W   = CAL_SHIFT;

    localparam logic [1:0] OP_INTEGRATE = 2'd0;
    localparam logic [1:0] OP_CALIBRATE = 2'd1;
    localparam logic [1:0] OP_CLEAR     = 2'd2;

    typedef struct packed {
        logic              start;
        logic              neg;
        logic [PROD_W-1:0] mag;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_QW-1:0] quo;
    } t_div_rsp;

endpackage

// File: rtl/adr_if.sv
// adr_in_if / adr_out_if: valid-ready channels carrying one sample item and
// one result item. depends on adr_pkg for field widths.
interface adr_in_if import adr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               opcode;
    logic [TIME_W-1:0]        time_ms;
    logic signed [ACC_W-1:0]  accel_x;
    logic signed [ACC_W-1:0]  accel_y;
    logic signed [ACC_W-1:0]  accel_z;

    modport source (output valid, opcode, time_ms, accel_x, accel_y, accel_z,
                    input ready);
    modport sink   (input valid, opcode, time_ms, accel_x, accel_y, accel_z,
                    output ready);
endinterface

interface adr_out_if import adr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [VEL_W-1:0]  vel_x;
    logic signed [VEL_W-1:0]  vel_y;
    logic signed [VEL_W-1:0]  vel_z;
    logic                     calibration_done;

    modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                    calibration_done, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                    calibration_done, output ready);
endinterface

// File: rtl/adr_div.sv
// adr_div: shared floor divider by 2000 for signed values given as sign and
// 64-bit magnitude; eight quotient bits per cycle. depends on adr_pkg.
module adr_div import adr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_fin;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PROD_W-1:0]    r_dvd;
    logic [PROD_W-1:0]    r_quo;
    logic [DIV_REM_W-1:0] r_rem;
    logic                 r_neg;
    logic                 r_sticky;
    logic [DIV_QW-1:0]    r_res;

    logic [DIV_REM_W-1:0] w_rem;
    logic [DIV_DIGIT-1:0] w_q8;
    logic [DIV_REM_W:0]   w_t;
    logic                 w_up;
    logic [DIV_QW-1:0]    w_mag;
    logic [DIV_QW-1:0]    w_res;

    // eight restoring steps on a 7-bit remainder
    always_comb begin
        w_rem = r_rem;
        w_q8  = '0;
        w_t   = '0;
        for (int k = 0; k < DIV_DIGIT; k++) begin
            w_t = {w_rem, r_dvd[PROD_W-1-k]};
            if (w_t >= (DIV_REM_W+1)'(DIV_K)) begin
                w_rem = DIV_REM_W'(w_t - (DIV_REM_W+1)'(DIV_K));
                w_q8[DIV_DIGIT-1-k] = 1'b1;
            end else begin
                w_rem = w_t[DIV_REM_W-1:0];
            end
        end
    end

    // floor for negative values: round the magnitude up on any remainder
    assign w_up  = r_neg && ((r_rem != '0) || r_sticky);
    assign w_mag = {1'b0, r_quo[DIV_QW-2:0]} + {{(DIV_QW-1){1'b0}}, w_up};
    assign w_res = r_neg ? (~w_mag + {{(DIV_QW-1){1'b0}}, 1'b1}) : w_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd    <= {{DIV_SHIFT{1'b0}}, i_req.mag[PROD_W-1:DIV_SHIFT]};
            r_sticky <= |i_req.mag[DIV_SHIFT-1:0];
            r_neg    <= i_req.neg;
            r_rem    <= '0;
            r_quo    <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[PROD_W-DIV_DIGIT-1:0], {DIV_DIGIT{1'b0}}};
            r_quo <= {r_quo[PROD_W-DIV_DIGIT-1:0], w_q8};
            r_rem <= w_rem;
        end
        if (r_fin) begin
            r_res <= w_res;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_res;

endmodule

// File: rtl/accel_dead_reckoning_integrator_unit.sv
// accel_dead_reckoning_integrator_unit: top level, sequencer, axis state and
// shared 32x16 multiplier. depends on adr_pkg, adr_if and adr_div.
//
// Three-axis dead reckoning by trapezoidal double integration. One item is
// taken at a time and every item gives exactly one result. For an integrate
// item each axis runs two products through the shared multiplier, the second
// in a low and a high half, and two divisions by 2000 through the shared
// divider, which retires eight quotient bits per cycle (six divisions per
// item); the output register is loaded after the last axis. Calibrate and
// clear items pass through their own state (S_CAL or S_CLR) before the output
// state, and the unused opcode goes straight to it. The input is ready again once the
// result sits in the output register, even if it has not been taken yet.
module accel_dead_reckoning_integrator_unit import adr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    adr_in_if.sink    i_in,
    adr_out_if.source o_out
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CAL   = 11'b00000000010,
        S_CLR   = 11'b00000000100,
        S_APREP = 11'b00000001000,
        S_AMUL  = 11'b00000010000,
        S_ADIV  = 11'b00000100000,
        S_VPREP = 11'b00001000000,
        S_VMLO  = 11'b00010000000,
        S_VMHI  = 11'b00100000000,
        S_PDIV  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    // architectural state
    logic [TIME_W-1:0]    r_last_time;
    logic [ACOR_W-1:0]    r_prev[3];
    logic [VEL_W-1:0]     r_vel[3];
    logic [POS_W-1:0]     r_pos[3];
    logic [ACC_W-1:0]     r_off[3];
    logic [CAL_SUM_W-1:0] r_cal_sum[3];
    logic [CAL_CNT_W-1:0] r_cal_cnt;

    // working registers
    logic [ACC_W-1:0]     r_raw[3];
    logic [1:0]           r_ax;
    logic [DT_W-1:0]      r_dt;
    logic [ACOR_W-1:0]    r_a;
    logic [MAG_W-1:0]     r_mag_op;
    logic                 r_neg;
    logic [PROD_W-1:0]    r_prod;
    logic [VEL_W-1:0]     r_vold;
    logic                 r_go;
    logic                 r_done_flag;

    // output register
    logic                 r_out_valid;
    logic [POS_W-1:0]     r_out_pos[3];
    logic [VEL_W-1:0]     r_out_vel[3];
    logic                 r_out_done;

    t_div_req             w_div_req;
    t_div_rsp             w_div_rsp;

    logic                 w_in_xfer;
    logic                 w_out_load;
    logic [TIME_W-1:0]    w_dt_raw;
    logic [ACOR_W-1:0]    w_a;
    logic [ASUM_W-1:0]    w_asum;
    logic [ASUM_W-1:0]    w_amag;
    logic [MAG_W-1:0]     w_vsum;
    logic [MAG_W-1:0]     w_vmag;
    logic [MUL_A_W-1:0]   w_mul_a;
    logic [MUL_W-1:0]     w_mul;
    logic [VEL_W+8:0]     w_vnew_ext;
    logic [VEL_W-1:0]     w_vnew;
    logic [POS_W:0]       w_pnew_ext;
    logic [POS_W-1:0]     w_pnew;
    logic [CAL_SUM_W-1:0] w_cal_sum[3];
    logic                 w_cal_last;

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || o_out.ready);
    assign i_in.ready = (r_state == S_IDLE);

    assign w_dt_raw = i_in.time_ms - r_last_time;

    // corrected sample and trapezoid sum for the current axis
    assign w_a    = {r_raw[r_ax][ACC_W-1], r_raw[r_ax]} - {r_off[r_ax][ACC_W-1], r_off[r_ax]};
    assign w_asum = {w_a[ACOR_W-1], w_a} + {r_prev[r_ax][ACOR_W-1], r_prev[r_ax]};
    assign w_amag = w_asum[ASUM_W-1] ? (~w_asum + 1'b1) : w_asum;

    assign w_vsum = {r_vel[r_ax][VEL_W-1], r_vel[r_ax]} + {r_vold[VEL_W-1], r_vold};
    assign w_vmag = w_vsum[MAG_W-1] ? (~w_vsum + 1'b1) : w_vsum;

    // shared multiplier: low word of the operand, or its high part
    assign w_mul_a = (r_state == S_VMHI)
                   ? {{(2*MUL_A_W-MAG_W){1'b0}}, r_mag_op[MAG_W-1:MUL_A_W]}
                   : r_mag_op[MUL_A_W-1:0];
    assign w_mul   = w_mul_a * r_dt;

    // saturating velocity and position updates
    assign w_vnew_ext = {{9{r_vel[r_ax][VEL_W-1]}}, r_vel[r_ax]}
                      + {w_div_rsp.quo[DIV_QW-1], w_div_rsp.quo};
    always_comb begin
        if (w_vnew_ext[VEL_W+8:VEL_W-1] == '0
                || w_vnew_ext[VEL_W+8:VEL_W-1] == '1) begin
            w_vnew = w_vnew_ext[VEL_W-1:0];
        end else begin
            w_vnew = {w_vnew_ext[VEL_W+8], {(VEL_W-1){~w_vnew_ext[VEL_W+8]}}};
        end
    end

    assign w_pnew_ext = {r_pos[r_ax][POS_W-1], r_pos[r_ax]}
                      + {{(POS_W+1-DIV_QW){w_div_rsp.quo[DIV_QW-1]}}, w_div_rsp.quo};
    always_comb begin
        if (w_pnew_ext[POS_W] == w_pnew_ext[POS_W-1]) begin
            w_pnew = w_pnew_ext[POS_W-1:0];
        end else begin
            w_pnew = {w_pnew_ext[POS_W], {(POS_W-1){~w_pnew_ext[POS_W]}}};
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_cal_sum[k] = r_cal_sum[k]
                         + {{CAL_SHIFT{r_raw[k][ACC_W-1]}}, r_raw[k]};
        end
    end
    assign w_cal_last = (r_cal_cnt == CAL_CNT_W'(CAL_SAMPLES - 1));

    assign w_div_req.start = r_go;
    assign w_div_req.neg   = r_neg;
    assign w_div_req.mag   = r_prod;

    adr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    priority case (i_in.opcode)
                        OP_INTEGRATE: n_state = S_APREP;
                        OP_CALIBRATE: n_state = S_CAL;
                        OP_CLEAR:     n_state = S_CLR;
                        default:      n_state = S_OUT;
                    endcase
                end
            end
            S_CAL:   n_state = S_OUT;
            S_CLR:   n_state = S_OUT;
            S_APREP: n_state = S_AMUL;
            S_AMUL:  n_state = S_ADIV;
            S_ADIV:  if (w_div_rsp.done) n_state = S_VPREP;
            S_VPREP: n_state = S_VMLO;
            S_VMLO:  n_state = S_VMHI;
            S_VMHI:  n_state = S_PDIV;
            S_PDIV: begin
                if (w_div_rsp.done) begin
                    n_state = (r_ax == 2'd2) ? S_OUT : S_APREP;
                end
            end
            S_OUT:   if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_time <= '0;
            r_cal_cnt   <= '0;
            for (int k = 0; k < 3; k++) begin
                r_prev[k]    <= '0;
                r_vel[k]     <= '0;
                r_pos[k]     <= '0;
                r_off[k]     <= '0;
                r_cal_sum[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_go    <= (r_state == S_AMUL) || (r_state == S_VMHI);

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_in_xfer && i_in.opcode == OP_INTEGRATE) begin
                r_last_time <= i_in.time_ms;
            end

            unique case (r_state)
                S_CAL: begin
                    if (w_cal_last) begin
                        r_cal_cnt <= '0;
                        for (int k = 0; k < 3; k++) begin
                            r_off[k]     <= w_cal_sum[k][CAL_SUM_W-1:CAL_SHIFT];
                            r_cal_sum[k] <= '0;
                        end
                    end else begin
                        r_cal_cnt <= r_cal_cnt + 1'b1;
                        for (int k = 0; k < 3; k++) begin
                            r_cal_sum[k] <= w_cal_sum[k];
                        end
                    end
                end
                S_CLR: begin
                    r_last_time <= '0;
                    r_cal_cnt   <= '0;
                    for (int k = 0; k < 3; k++) begin
                        r_prev[k]    <= '0;
                        r_vel[k]     <= '0;
                        r_pos[k]     <= '0;
                        r_off[k]     <= '0;
                        r_cal_sum[k] <= '0;
                    end
                end
                S_ADIV: begin
                    if (w_div_rsp.done) begin
                        r_vel[r_ax]  <= w_vnew;
                        r_prev[r_ax] <= r_a;
                    end
                end
                S_PDIV: begin
                    if (w_div_rsp.done) begin
                        r_pos[r_ax] <= w_pnew;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_raw[0]    <= i_in.accel_x;
            r_raw[1]    <= i_in.accel_y;
            r_raw[2]    <= i_in.accel_z;
            r_ax        <= 2'd0;
            r_done_flag <= 1'b0;
            r_dt        <= (|w_dt_raw[TIME_W-1:DT_W]) ? '1 : w_dt_raw[DT_W-1:0];
        end

        unique case (r_state)
            S_CAL: begin
                r_done_flag <= w_cal_last;
            end
            S_APREP: begin
                r_a      <= w_a;
                r_neg    <= w_asum[ASUM_W-1];
                r_mag_op <= {{(MAG_W-ASUM_W){1'b0}}, w_amag};
            end
            S_AMUL: begin
                // the 2^16 velocity scale goes in ahead of the division
                r_prod <= {w_mul, {(PROD_W-MUL_W){1'b0}}};
            end
            S_ADIV: begin
                if (w_div_rsp.done) begin
                    r_vold <= r_vel[r_ax];
                end
            end
            S_VPREP: begin
                r_neg    <= w_vsum[MAG_W-1];
                r_mag_op <= w_vmag;
            end
            S_VMLO: begin
                r_prod <= {{(PROD_W-MUL_W){1'b0}}, w_mul};
            end
            S_VMHI: begin
                r_prod <= r_prod + {w_mul[PROD_W-MUL_A_W-1:0], {MUL_A_W{1'b0}}};
            end
            S_PDIV: begin
                if (w_div_rsp.done) begin
                    r_ax <= r_ax + 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (w_out_load) begin
            for (int k = 0; k < 3; k++) begin
                r_out_pos[k] <= r_pos[k];
                r_out_vel[k] <= r_vel[k];
            end
            r_out_done <= r_done_flag;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.pos_x            = r_out_pos[0];
    assign o_out.pos_y            = r_out_pos[1];
    assign o_out.pos_z            = r_out_pos[2];
    assign o_out.vel_x            = r_out_vel[0];
    assign o_out.vel_y            = r_out_vel[1];
    assign o_out.vel_z            = r_out_vel[2];
    assign o_out.calibration_done = r_out_done;

endmodule

// File: test/testbench.sv
// testbench: streams sample items through the dead reckoning integrator and
// checks each result against a fixed-point predictor kept in this module.
// depends on adr_pkg, adr_if and accel_dead_reckoning_integrator_unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import adr_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int N_ITEMS     = 1150;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 100;
    localparam int ACC_FULL    = 65536;   // spread that means uniform over the field
    localparam int PHASE_LEN   = 60;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [TIME_W-1:0]       time_ms;
        logic signed [ACC_W-1:0] ax;
        logic signed [ACC_W-1:0] ay;
        logic signed [ACC_W-1:0] az;
    } t_sample;

    typedef struct packed {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic signed [VEL_W-1:0] vz;
        logic                    done;
    } t_fix;

    typedef struct packed {
        t_sample s;
        logic    zero_expected;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    adr_in_if  in_if ();
    adr_out_if out_if ();

    accel_dead_reckoning_integrator_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_fix              expected_fixes [$];
    t_row              directed_rows [$];
    int                n_fail = 0;
    int                n_counted = 0;
    int                n_xfers = 0;
    int                tx_idle_pct = 0;
    int                rx_stall_pct = 0;
    int                quiet_cycles = 0;
    logic [TIME_W-1:0] stamp = '0;

    // integrator state as the predictor sees it
    logic [TIME_W-1:0]        nav_last_time;
    logic signed [ACOR_W-1:0] nav_prev_acc [3];
    logic signed [VEL_W-1:0]  nav_vel [3];
    logic signed [POS_W-1:0]  nav_pos [3];
    logic signed [ACC_W-1:0]  nav_offset [3];
    longint                   nav_cal_sum [3];
    int                       nav_cal_cnt;

    function automatic void clear_nav();
        nav_last_time = '0;
        nav_cal_cnt = 0;
        for (int i = 0; i < 3; i++) begin
            nav_prev_acc[i] = '0;
            nav_vel[i] = '0;
            nav_pos[i] = '0;
            nav_offset[i] = '0;
            nav_cal_sum[i] = 0;
        end
    endfunction

    // floor(s * dt / 2000), exact at 128 bits
    function automatic logic signed [127:0] scale_dt(input logic signed [127:0] s,
                                                     input logic [DT_W-1:0] dt);
        logic signed [127:0] p;
        logic signed [127:0] q;
        p = s * $signed({112'd0, dt});
        q = p / 128'sd2000;
        if ((p < 0) && ((p % 128'sd2000) != 0))
            q = q - 128'sd1;
        return q;
    endfunction

    function automatic logic signed [127:0] saturate(input logic signed [127:0] v,
                                                     input int w);
        logic signed [127:0] top;
        top = (128'sd1 <<< (w - 1)) - 128'sd1;
        if (v > top)
            return top;
        if (v < -top - 128'sd1)
            return -top - 128'sd1;
        return v;
    endfunction

    function automatic t_fix advance_nav(input t_sample s);
        logic signed [ACC_W-1:0] raw [3];
        logic [TIME_W-1:0]       elapsed;
        logic [DT_W-1:0]         dt;
        logic signed [127:0]     corr;
        logic signed [127:0]     asum;
        logic signed [127:0]     v_old;
        logic signed [127:0]     v_new;
        t_fix                    r;
        raw[0] = s.ax;
        raw[1] = s.ay;
        raw[2] = s.az;
        r = '0;
        case (s.opcode)
            OP_INTEGRATE: begin
                elapsed = s.time_ms - nav_last_time;
                dt = (elapsed > 32'd65535) ? 16'hFFFF : elapsed[DT_W-1:0];
                nav_last_time = s.time_ms;
                for (int i = 0; i < 3; i++) begin
                    corr = 128'(raw[i]) - 128'(nav_offset[i]);
                    asum = corr + 128'(nav_prev_acc[i]);
                    v_old = 128'(nav_vel[i]);
                    v_new = saturate(v_old + scale_dt(asum * 65536, dt), VEL_W);
                    nav_prev_acc[i] = corr[ACOR_W-1:0];
                    nav_pos[i] = POS_W'(saturate(nav_pos[i] + scale_dt(v_new + v_old, dt),
                                                 POS_W));
                    nav_vel[i] = v_new[VEL_W-1:0];
                end
            end
            OP_CALIBRATE: begin
                for (int i = 0; i < 3; i++)
                    nav_cal_sum[i] += longint'(raw[i]);
                nav_cal_cnt++;
                if (nav_cal_cnt >= CAL_SAMPLES) begin
                    for (int i = 0; i < 3; i++) begin
                        nav_offset[i] = ACC_W'(nav_cal_sum[i] >>> CAL_SHIFT);
                        nav_cal_sum[i] = 0;
                    end
                    nav_cal_cnt = 0;
                    r.done = 1'b1;
                end
            end
            OP_CLEAR: clear_nav();
            default: ;
        endcase
        r.px = nav_pos[0];
        r.py = nav_pos[1];
        r.pz = nav_pos[2];
        r.vx = nav_vel[0];
        r.vy = nav_vel[1];
        r.vz = nav_vel[2];
        return r;
    endfunction

    function automatic void advance_stamp();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            stamp = stamp + $urandom_range(1, 200);
        else if (pick < 65)
            stamp = stamp;   // repeated timestamp, zero dt
        else if (pick < 75)
            stamp = stamp + 32'd65535 + $urandom_range(1);   // either side of the clamp
        else if (pick < 85)
            stamp = $urandom();
        else if (pick < 92)
            stamp = 32'hFFFF_FFFF - $urandom_range(300);     // next steps wrap
        else
            stamp = stamp + $urandom_range(32'h7FFF_FFFF, 32'h0001_0000);
    endfunction

    function automatic logic signed [ACC_W-1:0] jitter(input int bias, input int spread);
        int v;
        if (spread >= ACC_FULL)
            return ACC_W'($urandom());
        v = bias - spread + int'($urandom_range(2 * spread));
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return ACC_W'(v);
    endfunction

    function automatic int pick_bias();
        case ($urandom_range(3))
            0: return 0;
            1: return $urandom_range(1) ? 32767 : -32768;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic int pick_spread();
        case ($urandom_range(3))
            0: return 0;
            1: return 40;
            2: return 3000;
            default: return ACC_FULL;
        endcase
    endfunction

    function automatic t_sample make_sample(input logic [1:0] op, input logic [TIME_W-1:0] t,
                                            input int x, input int y, input int z);
        t_sample s;
        s.opcode = op;
        s.time_ms = t;
        s.ax = ACC_W'(x);
        s.ay = ACC_W'(y);
        s.az = ACC_W'(z);
        return s;
    endfunction

    function automatic t_row row(input t_sample s, input logic zero_expected = 1'b0);
        t_row r;
        r.s = s;
        r.zero_expected = zero_expected;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    task automatic send_sample(input t_sample s, input logic zero_expected = 1'b0);
        t_fix predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.opcode  <= s.opcode;
        in_if.time_ms <= s.time_ms;
        in_if.accel_x <= s.ax;
        in_if.accel_y <= s.ay;
        in_if.accel_z <= s.az;
        do @(posedge i_clk); while (!in_if.ready);
        predicted = advance_nav(s);
        if (zero_expected)
            predicted = '0;
        expected_fixes.push_back(predicted);
        if (s.opcode != OP_UNUSED)
            n_counted++;
        n_xfers++;
        if (n_xfers % PHASE_LEN == 0) begin
            case ((n_xfers / PHASE_LEN) % 4)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct = 64;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 64;
                end
                default: begin
                    tx_idle_pct = 27;
                    rx_stall_pct = 27;
                end
            endcase
        end
    endtask

    // hold the input off until every outstanding result is back
    task automatic drain();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_fixes.size() != 0);
    endtask

    task automatic calibrate_run(input int bx, input int by, input int bz, input int spread,
                                 input int stray_pct);
        int remaining;
        remaining = CAL_SAMPLES - nav_cal_cnt;
        while (remaining > 0) begin
            if ($urandom_range(99) < stray_pct) begin
                // integrate mid-run: the old offsets still apply
                advance_stamp();
                send_sample(make_sample(OP_INTEGRATE, stamp, jitter(0, ACC_FULL),
                                        jitter(0, ACC_FULL), jitter(0, ACC_FULL)));
            end else begin
                send_sample(make_sample(OP_CALIBRATE, $urandom(), jitter(bx, spread),
                                        jitter(by, spread), jitter(bz, spread)));
                remaining--;
            end
        end
    endtask

    task automatic motion_run(input int len, input int bx, input int by, input int bz,
                              input int spread, input logic full_dt);
        logic [1:0] op;
        repeat (len) begin
            op = ($urandom_range(99) < 3) ? OP_UNUSED : OP_INTEGRATE;
            if (full_dt)
                stamp = stamp + 32'd65535;
            else
                advance_stamp();
            send_sample(make_sample(op, stamp, jitter(bx, spread), jitter(by, spread),
                                    jitter(bz, spread)));
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_fix want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_fixes.size() == 0) begin
                $error("result transfer with no item outstanding");
                n_fail++;
            end else begin
                want = expected_fixes.pop_front();
                check_field("pos_x", want.px, out_if.pos_x);
                check_field("pos_y", want.py, out_if.pos_y);
                check_field("pos_z", want.pz, out_if.pos_z);
                check_field("vel_x", want.vx, out_if.vel_x);
                check_field("vel_y", want.vy, out_if.vel_y);
                check_field("vel_z", want.vz, out_if.vel_z);
                check_field("calibration_done", want.done, out_if.calibration_done);
            end
        end
    end

    initial out_if.ready = 1'b0;
    always @(posedge i_clk) out_if.ready <= ($urandom_range(99) >= rx_stall_pct);

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $error("no transfer for %0d cycles", QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int   bz;
        int   burst;
        logic sat_done;
        sat_done = 1'b0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.opcode = OP_INTEGRATE;
        in_if.time_ms = '0;
        in_if.accel_x = '0;
        in_if.accel_y = '0;
        in_if.accel_z = '0;
        clear_nav();

        // opcode 3 right after reset: nothing moves
        directed_rows.push_back(row(make_sample(OP_UNUSED, 32'hFFFF_FFFF, -1, -1, -1), 1'b1));
        // first integrate at time 0: dt is zero, only the accel history changes
        directed_rows.push_back(row(make_sample(OP_INTEGRATE, 32'h0, 32767, -32768, 0), 1'b1));
        directed_rows.push_back(row(make_sample(OP_INTEGRATE, 32'h1, 32767, -32768, 0)));
        // just past the dt clamp, then exactly on it
        directed_rows.push_back(row(make_sample(OP_INTEGRATE, 32'h0001_0002, -32768, 32767, -1)));
        directed_rows.push_back(row(make_sample(OP_INTEGRATE, 32'h0002_0001, 32767, -32768, 1)));
        directed_rows.push_back(row(make_sample(OP_INTEGRATE, 32'h0002_0001, 12345, -12345, 0)));
        directed_rows.push_back(row(make_sample(OP_INTEGRATE, 32'hFFFF_FFF0, -1, 1, 32767)));
        // timestamp wraps past zero, then steps backwards
        directed_rows.push_back(row(make_sample(OP_INTEGRATE, 32'h0000_0005, 0, 0, -32768)));
        directed_rows.push_back(row(make_sample(OP_INTEGRATE, 32'h0000_0004, 100, -100, 7)));
        directed_rows.push_back(row(make_sample(OP_UNUSED, 32'h5A5A_A5A5, 1, 2, 3)));
        // partial calibration: offsets must not change yet
        directed_rows.push_back(row(make_sample(OP_CALIBRATE, 32'h0, -32768, 32767, -32768)));
        directed_rows.push_back(row(make_sample(OP_CALIBRATE, 32'hFFFF_FFFF, 32767, -32768, 32767)));
        directed_rows.push_back(row(make_sample(OP_CALIBRATE, 32'h1234_5678, 500, -500, 9)));
        directed_rows.push_back(row(make_sample(OP_INTEGRATE, 32'h0000_0100, 300, -300, 30)));
        // clear drops the run in progress along with everything else
        directed_rows.push_back(row(make_sample(OP_CLEAR, 32'hFFFF_FFFF, -1, -1, -1), 1'b1));
        directed_rows.push_back(row(make_sample(OP_INTEGRATE, 32'd1000, 500, -500, 32767)));
        directed_rows.push_back(row(make_sample(OP_INTEGRATE, 32'd1017, -32768, 32767, -3)));
        directed_rows.push_back(row(make_sample(OP_CLEAR, 32'h0, 0, 0, 0), 1'b1));
        directed_rows.push_back(row(make_sample(OP_UNUSED, 32'h0, 32767, -32768, 0), 1'b1));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_sample(directed_rows[k].s, directed_rows[k].zero_expected);

        while (n_counted < N_ITEMS) begin
            if ($urandom_range(4) == 0)
                drain();
            if (!sat_done && n_counted > 250) begin
                // extreme offsets, then full-scale accel at max dt until velocity pins
                drain();
                send_sample(make_sample(OP_CLEAR, $urandom(), 0, 0, 0));
                bz = $urandom_range(1) ? 32767 : -32768;
                calibrate_run(-32768, 32767, -bz, 0, 0);
                motion_run(560, 32767, -32768, bz, 0, 1'b1);
                sat_done = 1'b1;
            end
            case ($urandom_range(9))
                0, 1: calibrate_run(pick_bias(), pick_bias(), pick_bias(), pick_spread(), 5);
                2, 3, 4, 5, 6: begin
                    motion_run($urandom_range(5, 60), pick_bias(), pick_bias(), pick_bias(),
                               pick_spread(), 1'b0);
                end
                7: send_sample(make_sample(OP_CLEAR, $urandom(), jitter(0, ACC_FULL),
                                           jitter(0, ACC_FULL), jitter(0, ACC_FULL)));
                8: begin
                    burst = $urandom_range(1, 10);
                    repeat (burst) begin
                        send_sample(make_sample(2'($urandom()), $urandom(), jitter(0, ACC_FULL),
                                                jitter(0, ACC_FULL), jitter(0, ACC_FULL)));
                    end
                end
                default: begin
                    // calibration cut short by a clear
                    burst = $urandom_range(1, 20);
                    repeat (burst) begin
                        send_sample(make_sample(OP_CALIBRATE, $urandom(), jitter(0, ACC_FULL),
                                                jitter(0, ACC_FULL), jitter(0, ACC_FULL)));
                    end
                    send_sample(make_sample(OP_CLEAR, $urandom(), 0, 0, 0));
                end
            endcase
        end

        in_if.valid <= 1'b0;
        while (expected_fixes.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_fail == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
